@@ sv/mlalu_pkg.sv @@
// Shared types and constants for the multiprecision limb ALU.
package mlalu_pkg;

   localparam int LIMB_BITS = 32;
   // Step counter holds up to two limbs' worth of steps (long divide)
   localparam int CNT_W = $clog2(2 * LIMB_BITS + 1);
   localparam logic [LIMB_BITS-1:0] LIMB_ONES = {LIMB_BITS{1'b1}};

   typedef logic [LIMB_BITS-1:0] limb_type;

   typedef enum logic [2:0] {
      MODE_ADD    = 3'd0,
      MODE_CPROP  = 3'd1,
      MODE_SUB    = 3'd2,
      MODE_BPROP  = 3'd3,
      MODE_MULADD = 3'd4,
      MODE_DIV    = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_PASS
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } fsm_type;

   // Request handed from the front end to the serial core
   typedef struct packed {
      logic       start;
      logic [2:0] mode;
      logic       first;
      limb_type   operand_a;
      limb_type   operand_b;
      limb_type   initial_carry;
   } core_req_type;

   // Status and result returned by the serial core
   typedef struct packed {
      logic     done;
      limb_type result_limb;
      limb_type carry_out;
      logic     div_by_zero;
   } core_rsp_type;

endpackage

@@ sv/mlalu_serial_core.sv @@
// Bit-serial datapath: add/subtract, shift-add multiply and restoring divide.
module mlalu_serial_core (
   input  logic                     clock,
   input  logic                     reset,
   input  mlalu_pkg::core_req_type  core_req,
   input  mlalu_pkg::limb_type      running_carry,
   output mlalu_pkg::core_rsp_type  core_rsp
);

   localparam int LB = mlalu_pkg::LIMB_BITS;
   localparam int CW = mlalu_pkg::CNT_W;

   mlalu_pkg::kind_type  kind_ff, kind_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [LB-1:0]        opa_ff, opa_in;
   logic [LB-1:0]        hi_ff, hi_in;
   logic [2*LB-1:0]      lo_ff, lo_in;
   logic [1:0]           k_ff, k_in;
   logic                 dz_ff, dz_in;

   logic [LB-1:0]        c_eff;
   logic [2:0]           add_sum;
   logic                 sub_bit;
   logic                 sub_borrow;
   logic [LB:0]          mul_sum;
   logic [LB:0]          div_trial;
   logic                 div_ge;
   logic [LB:0]          div_diff;

   // Pick the incoming running value for a new request
   always_comb begin
      c_eff = running_carry;
      if (core_req.first) begin
         case (core_req.mode)
            mlalu_pkg::MODE_SUB, mlalu_pkg::MODE_BPROP:
               c_eff = {{(LB-1){1'b0}}, core_req.initial_carry[0]};
            mlalu_pkg::MODE_DIV:
               c_eff = '0;
            default:
               c_eff = core_req.initial_carry;
         endcase
      end
   end

   // One step of each datapath kind
   always_comb begin
      add_sum    = 3'({2'b0, opa_ff[0]}) + 3'({2'b0, lo_ff[0]}) + 3'({2'b0, hi_ff[0]})
                   + 3'({1'b0, k_ff});
      sub_bit    = opa_ff[0] ^ lo_ff[0] ^ k_ff[0];
      sub_borrow = (~opa_ff[0] & lo_ff[0]) | (~opa_ff[0] & k_ff[0]) | (lo_ff[0] & k_ff[0]);
      mul_sum    = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, opa_ff} : {(LB+1){1'b0}});
      div_trial  = {hi_ff, lo_ff[2*LB-1]};
      div_ge     = (div_trial >= {1'b0, opa_ff});
      div_diff   = div_trial - {1'b0, opa_ff};
   end

   // Load a new request or advance the running one
   always_comb begin
      kind_in = kind_ff;
      cnt_in  = cnt_ff;
      opa_in  = opa_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      k_in    = k_ff;
      dz_in   = dz_ff;
      if (core_req.start) begin
         opa_in = core_req.operand_a;
         hi_in  = c_eff;
         lo_in  = {{LB{1'b0}}, core_req.operand_b};
         k_in   = 2'b00;
         dz_in  = 1'b0;
         cnt_in = CW'(LB);
         unique case (core_req.mode)
            mlalu_pkg::MODE_ADD: begin
               kind_in = mlalu_pkg::KIND_ADD;
            end
            mlalu_pkg::MODE_CPROP: begin
               kind_in = mlalu_pkg::KIND_ADD;
               lo_in   = '0;
            end
            mlalu_pkg::MODE_SUB: begin
               kind_in = mlalu_pkg::KIND_SUB;
               k_in    = {1'b0, c_eff[0]};
               hi_in   = '0;
            end
            mlalu_pkg::MODE_BPROP: begin
               kind_in = mlalu_pkg::KIND_SUB;
               k_in    = {1'b0, c_eff[0]};
               hi_in   = '0;
               lo_in   = '0;
            end
            mlalu_pkg::MODE_MULADD: begin
               kind_in = mlalu_pkg::KIND_MUL;
            end
            mlalu_pkg::MODE_DIV: begin
               if (core_req.operand_a == '0) begin
                  // Zero divisor: all-ones quotient, dividend limb as remainder
                  kind_in = mlalu_pkg::KIND_PASS;
                  lo_in   = {{LB{1'b0}}, mlalu_pkg::LIMB_ONES};
                  hi_in   = core_req.operand_b;
                  dz_in   = 1'b1;
                  cnt_in  = '0;
               end else if (c_eff < core_req.operand_a) begin
                  kind_in = mlalu_pkg::KIND_DIV;
                  lo_in   = {core_req.operand_b, {LB{1'b0}}};
               end else begin
                  // Remainder not reduced: divide the full two-limb value
                  kind_in = mlalu_pkg::KIND_DIV;
                  lo_in   = {c_eff, core_req.operand_b};
                  hi_in   = '0;
                  cnt_in  = CW'(2 * LB);
               end
            end
            default: begin
               kind_in = mlalu_pkg::KIND_PASS;
               lo_in   = '0;
               hi_in   = running_carry;
               cnt_in  = '0;
            end
         endcase
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CW'(1);
         unique case (kind_ff)
            mlalu_pkg::KIND_ADD: begin
               opa_in        = opa_ff >> 1;
               hi_in         = hi_ff >> 1;
               lo_in[LB-1:0] = {add_sum[0], lo_ff[LB-1:1]};
               k_in          = add_sum[2:1];
            end
            mlalu_pkg::KIND_SUB: begin
               opa_in        = opa_ff >> 1;
               lo_in[LB-1:0] = {sub_bit, lo_ff[LB-1:1]};
               k_in          = {1'b0, sub_borrow};
            end
            mlalu_pkg::KIND_MUL: begin
               hi_in         = mul_sum[LB:1];
               lo_in[LB-1:0] = {mul_sum[0], lo_ff[LB-1:1]};
            end
            mlalu_pkg::KIND_DIV: begin
               hi_in = div_ge ? div_diff[LB-1:0] : div_trial[LB-1:0];
               lo_in = {lo_ff[2*LB-2:0], div_ge};
            end
            default: begin
               cnt_in = '0;
            end
         endcase
      end
   end

   // Hold control state under reset; payload needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         kind_ff <= mlalu_pkg::KIND_PASS;
      end else begin
         cnt_ff  <= cnt_in;
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff <= opa_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      k_ff   <= k_in;
      dz_ff  <= dz_in;
   end

   // Present the result once all steps are done
   always_comb begin
      core_rsp.done        = (cnt_ff == '0);
      core_rsp.result_limb = lo_ff[LB-1:0];
      core_rsp.div_by_zero = dz_ff;
      if (kind_ff == mlalu_pkg::KIND_ADD || kind_ff == mlalu_pkg::KIND_SUB) begin
         core_rsp.carry_out = {{(LB-2){1'b0}}, k_ff};
      end else begin
         core_rsp.carry_out = hi_ff;
      end
   end

endmodule

@@ sv/multiprecision_limb_alu_unit.sv @@
// Top level of the multiprecision limb ALU: handshakes, running value, result register.
//
// Streams one 32-bit limb per request and keeps a running 32-bit carry, borrow
// or remainder between requests. The request channel (req_valid/req_ready)
// carries mode, first, both operands and the initial carry; the result channel
// (rsp_valid/rsp_ready) carries the result limb, the new running value and the
// divide-by-zero flag. One result per request, in order.
// Add, subtract and multiply-add run one bit per cycle through the serial
// core; the result is loaded into the result register when the core is done,
// and a new request is taken only once the unit is back in idle.
// Divide with a running remainder below the divisor takes the same; when the
// remainder is not below the divisor the core walks both limbs, so it takes
// longer. A zero divisor and the unused modes skip the serial steps.
// The step count of the bit-serial core sets the duration of each request.
// Reset (synchronous, active high) clears the running value to zero, empties
// the result register and returns the unit to idle.
// When the receiver stalls, the finished result waits in the core until the
// result register is free; no request is taken meanwhile.
module multiprecision_limb_alu_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic        req_first,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic [31:0] req_initial_carry,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_limb,
   output logic [31:0] rsp_carry_out,
   output logic        rsp_div_by_zero
);

   mlalu_pkg::fsm_type       state_ff, state_in;
   mlalu_pkg::limb_type      running_ff, running_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mlalu_pkg::limb_type      rsp_result_ff;
   mlalu_pkg::limb_type      rsp_carry_ff;
   logic                     rsp_dz_ff;
   mlalu_pkg::core_req_type  core_req;
   mlalu_pkg::core_rsp_type  core_rsp;
   logic                     req_take;
   logic                     rsp_load;

   // Bundle the request for the serial core
   always_comb begin
      core_req.start         = req_take;
      core_req.mode          = req_mode;
      core_req.first         = req_first;
      core_req.operand_a     = req_operand_a;
      core_req.operand_b     = req_operand_b;
      core_req.initial_carry = req_initial_carry;
   end

   mlalu_serial_core u_core (
      .clock         (clock),
      .reset         (reset),
      .core_req      (core_req),
      .running_carry (running_ff),
      .core_rsp      (core_rsp)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlalu_pkg::ST_IDLE: begin
            if (req_valid) state_in = mlalu_pkg::ST_BUSY;
         end
         mlalu_pkg::ST_BUSY: begin
            if (core_rsp.done && (!rsp_valid_ff || rsp_ready)) state_in = mlalu_pkg::ST_IDLE;
         end
         default: state_in = mlalu_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         mlalu_pkg::ST_IDLE: req_ready = 1'b1;
         mlalu_pkg::ST_BUSY: rsp_load  = core_rsp.done && (!rsp_valid_ff || rsp_ready);
         default: begin
            req_ready = 1'b0;
            rsp_load  = 1'b0;
         end
      endcase
   end

   assign req_take = req_valid && req_ready;

   // Advance running value and result valid
   always_comb begin
      running_in   = rsp_load ? core_rsp.carry_out : running_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlalu_pkg::ST_IDLE;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_result_ff <= core_rsp.result_limb;
         rsp_carry_ff  <= core_rsp.carry_out;
         rsp_dz_ff     <= core_rsp.div_by_zero;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_limb = rsp_result_ff;
   assign rsp_carry_out   = rsp_carry_ff;
   assign rsp_div_by_zero = rsp_dz_ff;

endmodule
